>>> rtl/core/ibus_frame_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef IBUS_FRAME_DECODER_MACROS_SVH
`define IBUS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define IBFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibfd check failed");

// Next-cycle implication, ignored while reset is asserted.
`define IBFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ibfd check failed");

`endif

>>> rtl/core/ibfd_pkg.sv
`timescale 1ns / 1ps
package ibfd_pkg;

  localparam int CHANNEL_COUNT = 14;
  localparam int BUF_IDX_W     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int CH_IDX_W      = 4;
  localparam int POS_W         = 5;

  localparam logic [7:0]       HEADER_BYTE = 8'h20;
  localparam logic [15:0]      CHECK_INIT  = 16'hFFFF;
  localparam logic [POS_W-1:0] CHECK_POS   = 5'd30;
  localparam logic [POS_W-1:0] LAST_POS    = 5'd31;
  localparam logic [POS_W-1:0] FIRST_DATA  = 5'd2;

  localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(CHANNEL_COUNT - 1);
  localparam logic [BUF_IDX_W-1:0] LAST_BUF = BUF_IDX_W'(CHANNEL_COUNT - 1);

  // Queue write side: one channel word per push.
  typedef struct packed {
    logic        push;
    logic [15:0] data;
  } ibfd_qwr_t;

  // Queue read side status.
  typedef struct packed {
    logic        empty;
    logic [15:0] data;
  } ibfd_qrd_t;

endpackage

>>> rtl/core/ibfd_in_if.sv
`timescale 1ns / 1ps
interface ibfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/ibfd_out_if.sv
`timescale 1ns / 1ps
interface ibfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ibfd_pkg::CH_IDX_W-1:0] channel_index;
  logic [15:0]                   channel_value;
  logic                          last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

>>> rtl/core/ibfd_front.sv
`timescale 1ns / 1ps
`include "ibus_frame_decoder_macros.svh"
module ibfd_front (
  input  logic                clk,
  input  logic                rst_n,
  ibfd_in_if.sink             in_bus,
  output ibfd_pkg::ibfd_qwr_t q_wr,
  input  logic                q_full
);
  import ibfd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'b001,
    ST_FRAME = 3'b010,
    ST_DRAIN = 3'b100
  } front_state_t;

  front_state_t         state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [15:0]          csum_r, csum_nxt;
  logic [7:0]           csum_lo_r;
  logic [7:0]           pend_r;
  logic [15:0]          buf_r [CHANNEL_COUNT];
  logic [BUF_IDX_W-1:0] sweep_r, sweep_nxt;
  logic                 xfer;
  logic [CH_IDX_W-1:0]  wr_k;
  logic                 csum_ok;

  assign in_bus.ready = (state_r != ST_DRAIN);
  assign xfer         = in_bus.valid && in_bus.ready;
  assign wr_k         = pos_r[4:1] - 4'd1;
  assign csum_ok      = ({in_bus.rx_byte, csum_lo_r} == csum_r);

  assign q_wr.push = (state_r == ST_DRAIN) && !q_full;
  assign q_wr.data = buf_r[sweep_r];

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    csum_nxt  = csum_r;
    sweep_nxt = sweep_r;
    unique case (state_r)
      ST_HUNT: begin
        if (xfer && in_bus.rx_byte == HEADER_BYTE) begin
          state_nxt = ST_FRAME;
          pos_nxt   = POS_W'(1);
          csum_nxt  = CHECK_INIT - {8'd0, HEADER_BYTE};
        end
      end
      ST_FRAME: begin
        if (xfer) begin
          pos_nxt = pos_r + POS_W'(1);
          if (pos_r < CHECK_POS) begin
            csum_nxt = csum_r - {8'd0, in_bus.rx_byte};
          end else if (pos_r == LAST_POS) begin
            // Good checksum: hand the words over, else drop the frame.
            state_nxt = csum_ok ? ST_DRAIN : ST_HUNT;
            pos_nxt   = '0;
            csum_nxt  = CHECK_INIT;
            sweep_nxt = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (!q_full) begin
          if (sweep_r == LAST_BUF) begin
            state_nxt = ST_HUNT;
          end else begin
            sweep_nxt = sweep_r + BUF_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      pos_r   <= '0;
      csum_r  <= CHECK_INIT;
      sweep_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      csum_r  <= csum_nxt;
      sweep_r <= sweep_nxt;
    end
  end

  // Frame payload capture.
  always_ff @(posedge clk) begin
    if (state_r == ST_FRAME && xfer) begin
      if (pos_r == CHECK_POS) begin
        csum_lo_r <= in_bus.rx_byte;
      end else if (pos_r < CHECK_POS && pos_r >= FIRST_DATA) begin
        if (!pos_r[0]) begin
          pend_r <= in_bus.rx_byte;
        end else if (wr_k < CH_IDX_W'(CHANNEL_COUNT)) begin
          buf_r[wr_k[BUF_IDX_W-1:0]] <= {in_bus.rx_byte, pend_r};
        end
      end
    end
  end

  `IBFD_ASSERT_NOW(a_drain_blocks_input, state_r == ST_DRAIN, !in_bus.ready)
endmodule

>>> rtl/core/ibfd_queue.sv
`timescale 1ns / 1ps
`include "ibus_frame_decoder_macros.svh"
module ibfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ibfd_pkg::ibfd_qwr_t q_wr,
  output logic                q_full,
  input  logic                q_pop,
  output ibfd_pkg::ibfd_qrd_t q_rd
);
  import ibfd_pkg::*;

  logic [15:0] mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_pop;

  assign q_full     = (cnt_r == 2'd2);
  assign q_rd.empty = (cnt_r == 2'd0);
  assign q_rd.data  = mem_r[rp_r];
  assign do_pop     = q_pop && !q_rd.empty;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({q_wr.push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_wr.push) wp_r <= ~wp_r;
      if (do_pop)    rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wp_r] <= q_wr.data;
  end

  `IBFD_ASSERT_NOW(a_no_overflow, q_wr.push, !q_full)
  `IBFD_ASSERT_NOW(a_count_bound, 1'b1, cnt_r != 2'd3)
endmodule

>>> rtl/core/ibfd_back.sv
`timescale 1ns / 1ps
`include "ibus_frame_decoder_macros.svh"
module ibfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ibfd_pkg::ibfd_qrd_t q_rd,
  output logic                q_pop,
  ibfd_out_if.source          out_bus
);
  import ibfd_pkg::*;

  logic                valid_r;
  logic [CH_IDX_W-1:0] idx_r, cnt_r;
  logic [15:0]         val_r;
  logic                last_r;
  logic                load;

  assign load  = (!valid_r || out_bus.ready) && !q_rd.empty;
  assign q_pop = load;

  assign out_bus.valid         = valid_r;
  assign out_bus.channel_index = idx_r;
  assign out_bus.channel_value = val_r;
  assign out_bus.last_channel  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        cnt_r   <= (cnt_r == LAST_IDX) ? '0 : cnt_r + CH_IDX_W'(1);
      end else if (out_bus.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Words arrive in channel order, a whole frame at a time.
  always_ff @(posedge clk) begin
    if (load) begin
      val_r  <= q_rd.data;
      idx_r  <= cnt_r;
      last_r <= (cnt_r == LAST_IDX);
    end
  end

  `IBFD_ASSERT_NOW(a_last_idx, valid_r && last_r, idx_r == LAST_IDX)
  `IBFD_ASSERT_NEXT(a_cnt_restart, valid_r && last_r && out_bus.ready && !load,
                    cnt_r == '0)
endmodule

>>> rtl/core/ibus_frame_decoder.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                        Handshake
// in_bus    in   rx_byte[7:0]                                   valid/ready
// out_bus   out  channel_index[3:0] channel_value[15:0] last    valid/ready
//
// The front accepts received bytes back to back while in_bus.ready is high.
// After a frame's final byte with a good checksum, the front moves the 14 channel words,
// one at a time, into a two-entry queue; in_bus.ready is low during that time.
// Results leave one per cycle through the output register while out_bus.ready is high.
// Reset (rst_n low, synchronous) returns to hunting for the header and empties the queue.
// A stall on out_bus fills the queue and holds the front's word sweep until it drains.
module ibus_frame_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ibfd_in_if.sink    in_bus,
  ibfd_out_if.source out_bus
);
  import ibfd_pkg::*;

  ibfd_qwr_t q_wr;
  ibfd_qrd_t q_rd;
  logic      q_full;
  logic      q_pop;

  // Front: hunt for the header, track position and checksum, buffer channel words.
  ibfd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_wr   (q_wr),
    .q_full (q_full)
  );

  // Queue: decouple the word sweep from the output stall.
  ibfd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_rd   (q_rd)
  );

  // Back: number the words, mark the last channel, hold the result for transfer.
  ibfd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rd    (q_rd),
    .q_pop   (q_pop),
    .out_bus (out_bus)
  );
endmodule
